// ===== rtl/tep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp parser package
// Shared types, codes and date constants for the timestamp-to-epoch parser.
// ----------------------------------------------------------------------------
package tep_pkg;

    localparam int DAYS_PER_ERA = 146097;
    localparam int EPOCH_SHIFT  = 719468;
    localparam int SECS_PER_DAY = 86400;
    localparam int YEAR_MIN     = 1970;
    localparam int YEAR_MAX     = 2100;

    // Day offsets of the two eras in range (years 1600..1999 and 2000..2399).
    localparam logic signed [20:0] ERA4_BASE = 21'(4 * DAYS_PER_ERA - EPOCH_SHIFT);
    localparam logic signed [20:0] ERA5_BASE = 21'(5 * DAYS_PER_ERA - EPOCH_SHIFT);

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } in_t;

    typedef struct packed {
        logic signed [32:0] epoch_seconds;
        logic               valid_res;
    } out_t;

    typedef enum logic [2:0] {
        PH_DATETIME   = 3'd0,
        PH_SUFFIX     = 3'd1,
        PH_FRAC_FIRST = 3'd2,
        PH_FRAC_MORE  = 3'd3,
        PH_ZULU       = 3'd4,
        PH_OFFSET     = 3'd5,
        PH_DONE       = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DAYS = 2'd1,
        ST_MUL  = 2'd2,
        ST_OUT  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic take;       // parse the character on the input channel
        logic calc_days;  // civil date to day count, range check
        logic calc_mul;   // day count to seconds, time of day
        logic load_out;   // final sum into the output register
        logic clear;      // return the parser to its start state
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    // Days from March 1 to the first of the shifted month: (153 * am + 2) / 5.
    function automatic logic [8:0] days_before_month(input logic [3:0] am);
        logic [8:0] r;
        case (am)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tep_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp parser controller
// Sequences character intake, the three date-math steps and the result load.
// ----------------------------------------------------------------------------
module tep_ctrl import tep_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last,
    output logic    s_ready,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_DAYS;
                end
            end
            ST_DAYS: begin
                cmd.calc_days = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.calc_mul = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                // The output register frees up in the same cycle it is taken.
                if (!status.out_full || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

// ===== rtl/tep_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp parser datapath
// Character checks, decimal accumulators, date arithmetic and output register.
// ----------------------------------------------------------------------------
module tep_datapath import tep_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    cmd,
    input  in_t     s_data,
    input  logic    m_ready,
    output status_t status,
    output logic    m_valid,
    output out_t    m_data
);

    // Parser state.
    logic [4:0]  pos_reg, pos_next;
    phase_t      phase_reg, phase_next;
    logic        err_reg, err_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic        neg_reg, neg_next;
    logic [6:0]  ohour_reg, ohour_next;
    logic [6:0]  omin_reg, omin_next;

    // Date math registers.
    logic               ok_reg;
    logic signed [20:0] days_reg;
    logic signed [37:0] prod_reg;
    logic signed [21:0] tod_reg;

    // Output register.
    logic  out_valid_reg;
    out_t  out_reg;

    function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
        return 7'({v, 3'b000} + {v, 1'b0} + {3'b000, d});
    endfunction

    function automatic logic [13:0] acc14(input logic [13:0] v, input logic [3:0] d);
        return 14'({v, 3'b000} + {v, 1'b0} + {10'd0, d});
    endfunction

    // Per-character parse step.
    always_comb begin
        logic [7:0] c;
        logic [3:0] d;
        logic       is_dig;
        logic       is_zone;
        c          = s_data.character;
        d          = c[3:0];
        is_dig     = (c inside {["0":"9"]});
        is_zone    = (c == "Z") || (c == "+") || (c == "-");
        pos_next   = pos_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        neg_next   = neg_reg;
        ohour_next = ohour_reg;
        omin_next  = omin_reg;

        if (!err_reg) begin
            case (phase_reg)
                PH_DATETIME: begin
                    if ((pos_reg == 5'd4 || pos_reg == 5'd7) && c != "-") begin
                        err_next = 1'b1;
                    end else if (pos_reg == 5'd10 && c != "T") begin
                        err_next = 1'b1;
                    end else if ((pos_reg == 5'd13 || pos_reg == 5'd16) && c != ":") begin
                        err_next = 1'b1;
                    end else if (!(pos_reg inside {5'd4, 5'd7, 5'd10, 5'd13, 5'd16})
                                 && !is_dig) begin
                        err_next = 1'b1;
                    end else begin
                        if (!(pos_reg inside {5'd4, 5'd7, 5'd10, 5'd13, 5'd16})) begin
                            if (pos_reg < 5'd4) begin
                                year_next = acc14(year_reg, d);
                            end else if (pos_reg < 5'd7) begin
                                month_next = acc7(month_reg, d);
                            end else if (pos_reg < 5'd10) begin
                                day_next = acc7(day_reg, d);
                            end else if (pos_reg < 5'd13) begin
                                hour_next = acc7(hour_reg, d);
                            end else if (pos_reg < 5'd16) begin
                                min_next = acc7(min_reg, d);
                            end else begin
                                sec_next = acc7(sec_reg, d);
                            end
                        end
                        if (pos_reg >= 5'd18) begin
                            pos_next   = 5'd0;
                            phase_next = PH_SUFFIX;
                        end else begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                end
                PH_SUFFIX, PH_FRAC_MORE: begin
                    if (phase_reg == PH_SUFFIX && c == ".") begin
                        phase_next = PH_FRAC_FIRST;
                    end else if (phase_reg == PH_FRAC_MORE && is_dig) begin
                        phase_next = PH_FRAC_MORE;
                    end else if (c == "Z") begin
                        phase_next = PH_ZULU;
                    end else if (is_zone) begin
                        neg_next   = (c == "-");
                        pos_next   = 5'd0;
                        phase_next = PH_OFFSET;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_FRAC_FIRST: begin
                    if (is_dig) begin
                        phase_next = PH_FRAC_MORE;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_OFFSET: begin
                    if (pos_reg == 5'd2 && c != ":") begin
                        err_next = 1'b1;
                    end else if (pos_reg != 5'd2 && !is_dig) begin
                        err_next = 1'b1;
                    end else begin
                        if (pos_reg < 5'd2) begin
                            ohour_next = acc7(ohour_reg, d);
                        end else if (pos_reg > 5'd2) begin
                            omin_next = acc7(omin_reg, d);
                        end
                        if (pos_reg >= 5'd4) begin
                            pos_next   = 5'd0;
                            phase_next = PH_DONE;
                        end else begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                end
                default: begin
                    // Anything after the zone designator breaks the layout.
                    err_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            pos_reg   <= '0;
            phase_reg <= PH_DATETIME;
            err_reg   <= 1'b0;
            year_reg  <= '0;
            month_reg <= '0;
            day_reg   <= '0;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            neg_reg   <= 1'b0;
            ohour_reg <= '0;
            omin_reg  <= '0;
        end else if (cmd.take) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            neg_reg   <= neg_next;
            ohour_reg <= ohour_next;
            omin_reg  <= omin_next;
        end
    end

    // Step one: range check and days from civil date. Valid years keep the
    // adjusted year inside two eras, so the era is a single compare.
    logic               ok_next;
    logic signed [20:0] days_next;

    always_comb begin
        logic [13:0] ay;
        logic        era5;
        logic [8:0]  yoe;
        logic [1:0]  cent;
        logic [3:0]  am;
        logic [8:0]  doy;
        logic [17:0] doe;
        ay   = year_reg - {13'd0, (month_reg <= 7'd2)};
        era5 = (ay >= 14'd2000);
        yoe  = 9'(ay - (era5 ? 14'd2000 : 14'd1600));
        if (yoe < 9'd100) begin
            cent = 2'd0;
        end else if (yoe < 9'd200) begin
            cent = 2'd1;
        end else if (yoe < 9'd300) begin
            cent = 2'd2;
        end else begin
            cent = 2'd3;
        end
        am   = (month_reg > 7'd2) ? 4'(month_reg - 7'd3) : 4'(month_reg + 7'd9);
        doy  = 9'(days_before_month(am) + 9'(day_reg) - 9'd1);
        doe  = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(cent) + 18'(doy);
        days_next = $signed({3'b000, doe}) + (era5 ? ERA5_BASE : ERA4_BASE);

        ok_next = !err_reg && (phase_reg == PH_ZULU || phase_reg == PH_DONE)
                  && year_reg >= 14'(YEAR_MIN) && year_reg <= 14'(YEAR_MAX)
                  && month_reg >= 7'd1 && month_reg <= 7'd12
                  && day_reg >= 7'd1 && day_reg <= 7'd31
                  && hour_reg <= 7'd23 && min_reg <= 7'd59 && sec_reg <= 7'd60;
        if (phase_reg == PH_DONE && (ohour_reg > 7'd23 || omin_reg > 7'd59)) begin
            ok_next = 1'b0;
        end
    end

    // Step two: day count to seconds, and the time of day less the offset.
    logic signed [37:0] prod_next;
    logic signed [21:0] tod_next;

    always_comb begin
        logic [19:0]        clock_secs;
        logic [19:0]        off_mag;
        logic signed [21:0] off_signed;
        clock_secs = 20'(hour_reg) * 20'd3600 + 20'(min_reg) * 20'd60 + 20'(sec_reg);
        off_mag    = (20'(ohour_reg) * 20'd60 + 20'(omin_reg)) * 20'd60;
        if (phase_reg != PH_DONE) begin
            off_signed = '0;
        end else if (neg_reg) begin
            off_signed = -$signed({2'b00, off_mag});
        end else begin
            off_signed = $signed({2'b00, off_mag});
        end
        prod_next = 38'(days_reg) * 38'(SECS_PER_DAY);
        tod_next  = $signed({2'b00, clock_secs}) - off_signed;
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_days) begin
            ok_reg   <= ok_next;
            days_reg <= days_next;
        end
        if (cmd.calc_mul) begin
            prod_reg <= prod_next;
            tod_reg  <= tod_next;
        end
    end

    // Step three: final sum into the output register.
    logic signed [32:0] secs_sum;
    assign secs_sum = prod_reg[32:0] + 33'(tod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.epoch_seconds <= ok_reg ? secs_sum : '0;
            out_reg.valid_res     <= ok_reg;
        end
    end

    assign status.out_full = out_valid_reg;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;

endmodule

// ===== rtl/timestamp_to_epoch_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp to epoch parser
// Parses a streamed YYYY-MM-DDThh:mm:ss[.f+](Z|+hh:mm|-hh:mm) string into
// Unix epoch seconds with a valid flag.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle outside the date math. When the character
// marked last is transferred, the block stops taking input for the date math
// (days from civil date, multiply to seconds, final sum) and then loads the
// result into an output register, waiting longer if the previous result has
// not yet been taken.
// Invalid strings give zero seconds with the valid flag low.
module timestamp_to_epoch_parser import tep_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t    cmd;
    status_t status;

    tep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tep_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_ready (m_ready),
        .status  (status),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // An invalid string always reports zero seconds.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |-> (m_data.epoch_seconds == '0))
        else $error("invalid result with nonzero seconds");

    // The last character starts the date math, so intake pauses.
    a_last_pauses: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last) |=> !s_ready)
        else $error("input taken during date math");

    // Valid results never fall below the lowest reachable epoch seconds.
    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.valid_res) |->
            (m_data.epoch_seconds >= -33'sd86340))
        else $error("valid result below range");

endmodule

// ===== sim/timestamp_to_epoch_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp to epoch parser testbench
// Streams timestamp strings one character per transfer, predicts the epoch
// seconds and valid flag of every string, and checks each result transfer
// in order. Directed strings cover the range limits, the offset forms and
// the malformed layouts. Random strings follow, most of them well formed,
// with random gaps on both channels and long output stalls.
// ----------------------------------------------------------------------------
module timestamp_to_epoch_parser_tb import tep_pkg::*; ();

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_Z     = "Z";

    localparam int RANDOM_CHARS   = 240;
    localparam int RANDOM_STRINGS = 8;
    localparam int LONG_HOLD      = 300;

    class epoch_checker;
        phase_t      phase;
        logic [4:0]  pos;
        logic [13:0] year;
        logic [6:0]  month, day, hour, minute, second;
        logic        off_neg;
        logic [6:0]  off_hour, off_minute;
        logic        broken;
        out_t        expected_epochs[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_DATETIME;
            pos = '0;
            year = '0;
            month = '0;
            day = '0;
            hour = '0;
            minute = '0;
            second = '0;
            off_neg = 1'b0;
            off_hour = '0;
            off_minute = '0;
            broken = 1'b0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function int push_digit(int v, logic [7:0] c);
            return v * 10 + int'(c) - int'(CH_ZERO);
        endfunction

        function void take_datetime(logic [7:0] c);
            int p;
            p = pos;
            if (p == 4 || p == 7) begin
                if (c != CH_DASH) begin
                    broken = 1'b1;
                    return;
                end
            end else if (p == 10) begin
                if (c != CH_T) begin
                    broken = 1'b1;
                    return;
                end
            end else if (p == 13 || p == 16) begin
                if (c != CH_COLON) begin
                    broken = 1'b1;
                    return;
                end
            end else if (!is_digit(c)) begin
                broken = 1'b1;
                return;
            end else if (p < 4) begin
                year = 14'(push_digit(year, c));
            end else if (p < 7) begin
                month = 7'(push_digit(month, c));
            end else if (p < 10) begin
                day = 7'(push_digit(day, c));
            end else if (p < 13) begin
                hour = 7'(push_digit(hour, c));
            end else if (p < 16) begin
                minute = 7'(push_digit(minute, c));
            end else begin
                second = 7'(push_digit(second, c));
            end
            p++;
            if (p >= 19) begin
                pos = '0;
                phase = PH_SUFFIX;
            end else begin
                pos = 5'(p);
            end
        endfunction

        function bit take_zone(logic [7:0] c);
            if (c == CH_Z) begin
                phase = PH_ZULU;
                return 1'b1;
            end
            if (c == CH_PLUS || c == CH_DASH) begin
                off_neg = (c == CH_DASH);
                pos = '0;
                phase = PH_OFFSET;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_offset(logic [7:0] c);
            int p;
            p = pos;
            if (p == 2) begin
                if (c != CH_COLON) begin
                    broken = 1'b1;
                    return;
                end
            end else if (!is_digit(c)) begin
                broken = 1'b1;
                return;
            end else if (p < 2) begin
                off_hour = 7'(push_digit(off_hour, c));
            end else begin
                off_minute = 7'(push_digit(off_minute, c));
            end
            p++;
            if (p >= 5) begin
                pos = '0;
                phase = PH_DONE;
            end else begin
                pos = 5'(p);
            end
        endfunction

        function longint civil_days(longint y, longint m, longint d);
            longint ay, era, yoe, am, doy, doe;
            ay = y - ((m <= 2) ? 1 : 0);
            era = (ay >= 0 ? ay : ay - 399) / 400;
            yoe = ay - era * 400;
            am = (m > 2) ? m - 3 : m + 9;
            doy = (153 * am + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        endfunction

        // Updates the parse state with one accepted character and, on the
        // final character, queues the expected result.
        function void note_char(in_t item);
            bit     ok;
            longint secs, off, y, mo, d, h, mi, s;
            out_t   res;
            if (!broken) begin
                case (phase)
                    PH_DATETIME: take_datetime(item.character);
                    PH_SUFFIX: begin
                        if (item.character == CH_DOT) phase = PH_FRAC_FIRST;
                        else if (!take_zone(item.character)) broken = 1'b1;
                    end
                    PH_FRAC_FIRST: begin
                        if (is_digit(item.character)) phase = PH_FRAC_MORE;
                        else broken = 1'b1;
                    end
                    PH_FRAC_MORE: begin
                        if (!is_digit(item.character) && !take_zone(item.character))
                            broken = 1'b1;
                    end
                    PH_OFFSET: take_offset(item.character);
                    default: broken = 1'b1;
                endcase
            end
            if (!item.last) return;

            ok = !broken && (phase == PH_ZULU || phase == PH_DONE) &&
                 year >= 1970 && year <= 2100 && month >= 1 && month <= 12 &&
                 day >= 1 && day <= 31 && hour <= 23 && minute <= 59 && second <= 60;
            if (ok && phase == PH_DONE)
                ok = off_hour <= 23 && off_minute <= 59;

            secs = 0;
            if (ok) begin
                y = year;
                mo = month;
                d = day;
                h = hour;
                mi = minute;
                s = second;
                off = 0;
                if (phase == PH_DONE) begin
                    off = (longint'(off_hour) * 60 + longint'(off_minute)) * 60;
                    if (off_neg) off = -off;
                end
                secs = civil_days(y, mo, d) * 86400 + h * 3600 + mi * 60 + s - off;
            end
            res.epoch_seconds = 33'(secs);
            res.valid_res = ok;
            expected_epochs.push_back(res);
            restart();
        endfunction

        function void check_epoch(out_t got);
            out_t want;
            if (expected_epochs.size() == 0) begin
                $display("%0t: unexpected result, seconds %0d valid %0b",
                         $time, got.epoch_seconds, got.valid_res);
                errors++;
                return;
            end
            want = expected_epochs.pop_front();
            if (got.epoch_seconds !== want.epoch_seconds) begin
                $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                         $time, want.epoch_seconds, got.epoch_seconds);
                errors++;
            end
            if (got.valid_res !== want.valid_res) begin
                $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                         $time, want.valid_res, got.valid_res);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    epoch_checker sb = new();
    logic [7:0]   stamp[$];
    int           chars_sent;
    int           strings_sent;
    bit           hold_request;

    timestamp_to_epoch_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_epoch(m_data);
            if (s_valid && s_ready) sb.note_char(s_data);
        end
    end

    // Output side: random stalls, plus a long hold-off on request so that
    // the output register fills and the input stalls behind it.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic drive_char(logic [7:0] c, bit fin, bit quiet);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{character: c, last: fin};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_stamp(bit quiet);
        for (int i = 0; i < stamp.size(); i++)
            drive_char(stamp[i], i == stamp.size() - 1, quiet);
        stamp.delete();
        strings_sent++;
    endtask

    task automatic add_text(string txt);
        for (int i = 0; i < txt.len(); i++) stamp.push_back(txt[i]);
    endtask

    task automatic add_num(int v, int ndig);
        int pw;
        pw = 1;
        repeat (ndig - 1) pw *= 10;
        for (int k = 0; k < ndig; k++) begin
            stamp.push_back(8'(int'(CH_ZERO) + (v / pw) % 10));
            pw /= 10;
        end
    endtask

    task automatic send_text(string txt);
        add_text(txt);
        send_stamp(1'b0);
    endtask

    // Picks a value from the legal range most of the time, else any value
    // that fits the digit count.
    function automatic int pick_field(int lo, int hi, int top);
        if ($urandom_range(0, 99) < 88) return $urandom_range(lo, hi);
        return $urandom_range(0, top);
    endfunction

    task automatic make_random_stamp();
        int  n, p;
        if ($urandom_range(0, 99) < 10) begin
            n = $urandom_range(1, 30);
            repeat (n) stamp.push_back(8'($urandom_range(0, 255)));
            return;
        end
        add_num(pick_field(1970, 2100, 9999), 4);
        stamp.push_back(CH_DASH);
        add_num(pick_field(1, 12, 99), 2);
        stamp.push_back(CH_DASH);
        add_num(pick_field(1, 31, 99), 2);
        stamp.push_back(CH_T);
        add_num(pick_field(0, 23, 99), 2);
        stamp.push_back(CH_COLON);
        add_num(pick_field(0, 59, 99), 2);
        stamp.push_back(CH_COLON);
        add_num(pick_field(0, 60, 99), 2);
        if ($urandom_range(0, 99) < 40) begin
            stamp.push_back(CH_DOT);
            n = $urandom_range(1, 12);
            repeat (n) stamp.push_back(8'(int'(CH_ZERO) + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 1) == 0) begin
            stamp.push_back(CH_Z);
        end else begin
            stamp.push_back($urandom_range(0, 1) ? CH_DASH : CH_PLUS);
            add_num(pick_field(0, 23, 99), 2);
            stamp.push_back(CH_COLON);
            add_num(pick_field(0, 59, 99), 2);
        end
        // Roughly one string in five gets damaged.
        if ($urandom_range(0, 99) < 20) begin
            p = $urandom_range(0, stamp.size() - 1);
            case ($urandom_range(0, 3))
                0: stamp[p] = 8'($urandom_range(0, 255));
                1: begin
                    n = $urandom_range(1, stamp.size() - 1);
                    while (stamp.size() > n) void'(stamp.pop_back());
                end
                2: begin
                    n = $urandom_range(1, 3);
                    repeat (n) stamp.push_back($urandom_range(0, 1) ? CH_Z
                                               : 8'($urandom_range(0, 255)));
                end
                default: stamp.insert(p, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        hold_request = 1'b0;
        chars_sent = 0;
        strings_sent = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Range limits and offset extremes.
        send_text("1970-01-01T00:00:00Z");
        send_text("1970-01-01T00:00:00+23:59");
        send_text("2100-12-31T23:59:60-23:59");
        send_text("2024-02-31T12:34:56.5Z");
        send_text("1999-12-31T23:59:59.123456789012+05:30");
        // Malformed layouts.
        send_text("2000-01-01T00:00:00.Z");
        send_text("2020-06-15T08:00");
        send_text("2020-06-15T08:00:00+01:");
        send_text("2020-06-15T08:00:00ZZ");
        send_text("2020-06-15T08:00:00-02:000");
        send_text(" 2020-06-15T08:00:00Z");
        send_text("2020-6-15T08:00:00Z");
        send_text("+2020-06-15T08:00:00Z");
        // Fields just outside their ranges.
        send_text("1969-12-31T23:59:59Z");
        send_text("2101-01-01T00:00:00Z");
        send_text("2020-00-10T00:00:00Z");
        send_text("2020-13-10T00:00:00Z");
        send_text("2020-05-00T00:00:00Z");
        send_text("2020-05-32T00:00:00Z");
        send_text("2020-05-10T24:00:00Z");
        send_text("2020-05-10T00:60:00Z");
        send_text("2020-05-10T00:00:61Z");
        send_text("2020-05-10T00:00:00+24:00");
        send_text("2020-05-10T00:00:00-00:60");
        // A zero byte, a byte with the top bit set, and a one-byte string.
        add_text("2020-06-15T08:00:00");
        stamp.push_back(8'h00);
        add_text("Z");
        send_stamp(1'b0);
        add_text("2020");
        stamp.push_back(8'hFF);
        add_text("06-15T08:00:00Z");
        send_stamp(1'b0);
        send_text("Z");

        chars_sent = 0;
        strings_sent = 0;
        hold_request = 1'b1;
        while (chars_sent < RANDOM_CHARS || strings_sent < RANDOM_STRINGS) begin
            if (chars_sent > RANDOM_CHARS / 2 && chars_sent < RANDOM_CHARS / 2 + 40)
                hold_request = 1'b1;
            make_random_stamp();
            send_stamp($urandom_range(0, 99) < 30);
        end
        s_valid <= 1'b0;

        while (sb.expected_epochs.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
